// ----- hdl/hdg_pkg.sv -----
// shared types, widths and arc tangent table for the heading angle block
package hdg_pkg;

    // coordinate field width and packed stream widths
    localparam int COORD_W   = 16;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int IN_DATA_W = 4 * COORD_W;
    localparam int HEAD_W    = 16;

    // cordic datapath widths: x/y carry the 2^8 scale plus gain headroom
    localparam int PRE_SHIFT = 8;
    localparam int XY_W      = 28;
    // angle accumulator in degrees with 16 fractional bits
    localparam int Z_FRAC    = 16;
    localparam int Z_W       = 27;
    localparam int ATAN_W    = 23;

    localparam int ATAN_ENTRIES     = 24;
    localparam int CORDIC_STEPS_DEF = 16;

    // angle constants in accumulator units
    localparam logic signed [Z_W-1:0] Z_HALF_TURN = Z_W'(180 * 65536);
    localparam logic signed [Z_W-1:0] Z_QUARTER   = Z_W'(90 * 65536);

    // rounding and wrap in 1/128 degree units
    localparam int ROUND_SHIFT = Z_FRAC - 7;
    localparam int R_W         = Z_W - ROUND_SHIFT;
    localparam logic signed [R_W-1:0] R_HALF_TURN = R_W'(23040);
    localparam logic signed [R_W-1:0] R_FULL_TURN = R_W'(46080);
    localparam logic [HEAD_W-1:0] HEAD_ZERO_VEC   = HEAD_W'(11520);

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   zero;
    } hdg_vec_t;

    // round(atan(2^-i) * 180/pi * 65536)
    function automatic logic [ATAN_W-1:0] atan_entry(input logic [4:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = ATAN_W'(2949120);
            5'd1:    v = ATAN_W'(1740967);
            5'd2:    v = ATAN_W'(919879);
            5'd3:    v = ATAN_W'(466945);
            5'd4:    v = ATAN_W'(234379);
            5'd5:    v = ATAN_W'(117304);
            5'd6:    v = ATAN_W'(58666);
            5'd7:    v = ATAN_W'(29335);
            5'd8:    v = ATAN_W'(14668);
            5'd9:    v = ATAN_W'(7334);
            5'd10:   v = ATAN_W'(3667);
            5'd11:   v = ATAN_W'(1833);
            5'd12:   v = ATAN_W'(917);
            5'd13:   v = ATAN_W'(458);
            5'd14:   v = ATAN_W'(229);
            5'd15:   v = ATAN_W'(115);
            5'd16:   v = ATAN_W'(57);
            5'd17:   v = ATAN_W'(29);
            5'd18:   v = ATAN_W'(14);
            5'd19:   v = ATAN_W'(7);
            5'd20:   v = ATAN_W'(4);
            5'd21:   v = ATAN_W'(2);
            5'd22:   v = ATAN_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- hdl/heading_angle_degrees_top.sv -----
// heading angle from a source point to a target point, cordic cell chain
//
// Slave stream: one beat carries source_x, source_y, target_x, target_y,
// each 16 bit signed with 4 fractional bits. Master stream: one beat carries
// the heading in 1/128 degree units, signed, in (-180, 180] degrees, with 0
// toward negative y. Each input beat gives exactly one output beat, in order.
// The chain has CORDIC_STEPS + 2 register stages: one prestep stage, one
// cell per cordic step (steps capped at 24), one rounding stage.
// Throughput is one beat per cycle while m_tready is high; every stage is a
// register with its own valid bit, so each cell hands its vector on unless stalled.
// When the receiver stalls, the output beat holds and the chain keeps
// filling its empty stages; s_tready drops only once every stage is full.
// Reset clears all valid bits; the data registers are not reset.
module heading_angle_degrees_top #(
    parameter int CORDIC_STEPS = hdg_pkg::CORDIC_STEPS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // source_x, source_y, target_x, target_y
    input  logic [hdg_pkg::IN_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // heading
    output logic [hdg_pkg::HEAD_W-1:0]    m_tdata
);

    localparam int NUM_STEPS = (CORDIC_STEPS < hdg_pkg::ATAN_ENTRIES) ?
                               CORDIC_STEPS : hdg_pkg::ATAN_ENTRIES;

    hdg_pkg::hdg_vec_t stage_vec   [0:NUM_STEPS];
    logic              stage_valid [0:NUM_STEPS];
    logic              stage_ready [0:NUM_STEPS];

    hdg_prestep u_prestep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .out_valid (stage_valid[0]),
        .out_ready (stage_ready[0]),
        .out_vec   (stage_vec[0])
    );

    for (genvar i = 0; i < NUM_STEPS; i++)
    begin : g_cell
        hdg_cell #(
            .STEP (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[i]),
            .in_ready  (stage_ready[i]),
            .in_vec    (stage_vec[i]),
            .out_valid (stage_valid[i+1]),
            .out_ready (stage_ready[i+1]),
            .out_vec   (stage_vec[i+1])
        );
    end

    hdg_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stage_valid[NUM_STEPS]),
        .in_ready  (stage_ready[NUM_STEPS]),
        .in_vec    (stage_vec[NUM_STEPS]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .heading   (m_tdata)
    );

`ifndef SYNTH
    // an output beat never leaves (-180, 180] degrees
    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata) <= $signed(16'sd23040)) &&
                     ($signed(m_tdata) > -$signed(16'sd23040)))
        else $error("heading out of range");

    // an empty output stage lets the whole chain move
    a_chain_open: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready && stage_ready[0] && stage_ready[NUM_STEPS])
        else $error("chain stalled with empty output stage");

    // equal points are flagged as a zero vector in the prestep stage
    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready &&
         (s_tdata[15:0] == s_tdata[47:32]) && (s_tdata[31:16] == s_tdata[63:48]))
        |=> stage_valid[0] && stage_vec[0].zero)
        else $error("zero vector not flagged");
`endif

endmodule

// ----- hdl/hdg_prestep.sv -----
// difference vector, zero detect and quadrant prestep, one register stage
module hdg_prestep (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [hdg_pkg::IN_DATA_W-1:0]      in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output hdg_pkg::hdg_vec_t                  out_vec
);

    localparam int CW = hdg_pkg::COORD_W;
    localparam int DW = hdg_pkg::DIFF_W;
    localparam int XW = hdg_pkg::XY_W;

    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    hdg_pkg::hdg_vec_t    vec_next;
    hdg_pkg::hdg_vec_t    vec_reg;
    logic                 valid_reg;

    always_comb
    begin
        dx = DW'($signed(in_data[3*CW-1:2*CW])) - DW'($signed(in_data[CW-1:0]));
        dy = DW'($signed(in_data[4*CW-1:3*CW])) - DW'($signed(in_data[2*CW-1:CW]));
        xs = XW'(dx) <<< hdg_pkg::PRE_SHIFT;
        ys = XW'(dy) <<< hdg_pkg::PRE_SHIFT;
        vec_next.zero = (dx == '0) && (dy == '0);
        if (dx[DW-1])
        begin
            // left half plane: flip the vector and start from a half turn
            vec_next.x = -xs;
            vec_next.y = -ys;
            vec_next.z = dy[DW-1] ? -hdg_pkg::Z_HALF_TURN : hdg_pkg::Z_HALF_TURN;
        end
        else
        begin
            vec_next.x = xs;
            vec_next.y = ys;
            vec_next.z = '0;
        end
    end

    assign in_ready = ~valid_reg | out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            vec_reg <= vec_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

endmodule

// ----- hdl/hdg_cell.sv -----
// one cordic vectoring cell: fixed shift, one arc tangent entry, one register stage
module hdg_cell #(
    parameter int STEP = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  hdg_pkg::hdg_vec_t in_vec,
    output logic              out_valid,
    input  logic              out_ready,
    output hdg_pkg::hdg_vec_t out_vec
);

    localparam int XW = hdg_pkg::XY_W;
    localparam int ZW = hdg_pkg::Z_W;
    localparam logic [ZW-1:0] ATAN_Z =
        ZW'(hdg_pkg::atan_entry(5'(STEP)));

    logic signed [XW-1:0] x_in;
    logic signed [XW-1:0] y_in;
    logic signed [XW-1:0] x_sh;
    logic signed [XW-1:0] y_sh;
    hdg_pkg::hdg_vec_t    vec_next;
    hdg_pkg::hdg_vec_t    vec_reg;
    logic                 valid_reg;

    always_comb
    begin
        x_in = in_vec.x;
        y_in = in_vec.y;
        x_sh = x_in >>> STEP;
        y_sh = y_in >>> STEP;
        vec_next.zero = in_vec.zero;
        if (!y_in[XW-1])
        begin
            // clockwise
            vec_next.x = x_in + y_sh;
            vec_next.y = y_in - x_sh;
            vec_next.z = in_vec.z + ATAN_Z;
        end
        else
        begin
            vec_next.x = x_in - y_sh;
            vec_next.y = y_in + x_sh;
            vec_next.z = in_vec.z - ATAN_Z;
        end
    end

    assign in_ready = ~valid_reg | out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            vec_reg <= vec_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

endmodule

// ----- hdl/hdg_post.sv -----
// quarter turn offset, rounding to 1/128 degree, wrap, output register
module hdg_post (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  hdg_pkg::hdg_vec_t           in_vec,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [hdg_pkg::HEAD_W-1:0]  heading
);

    localparam int ZW = hdg_pkg::Z_W;
    localparam int RW = hdg_pkg::R_W;
    localparam int HW = hdg_pkg::HEAD_W;
    localparam logic signed [ZW-1:0] ROUND_HALF = ZW'(1 << (hdg_pkg::ROUND_SHIFT - 1));

    logic signed [ZW-1:0] h_sum;
    logic signed [RW-1:0] r_val;
    logic [HW-1:0]        head_next;
    logic [HW-1:0]        head_reg;
    logic                 valid_reg;

    always_comb
    begin
        h_sum = in_vec.z + hdg_pkg::Z_QUARTER + ROUND_HALF;
        r_val = h_sum[ZW-1:hdg_pkg::ROUND_SHIFT];
        if (in_vec.zero)
        begin
            head_next = hdg_pkg::HEAD_ZERO_VEC;
        end
        else if (r_val > hdg_pkg::R_HALF_TURN)
        begin
            head_next = HW'(r_val - hdg_pkg::R_FULL_TURN);
        end
        else
        begin
            head_next = HW'(r_val);
        end
    end

    assign in_ready = ~valid_reg | out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            head_reg <= head_next;
        end
    end

    assign out_valid = valid_reg;
    assign heading   = head_reg;

endmodule
